FILE: rtl/core/smed_pkg.sv
// shared constants, types and sequencer states of the sliding median block
`default_nettype none

package smed_pkg;

    localparam int SAMPLE_W     = 8;
    localparam int WINDOW_DEF   = 60;
    localparam int BIT_IDX_W    = $clog2(SAMPLE_W);
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam int OUT_DATA_W   = 16;

    localparam logic [SAMPLE_W-1:0] THRESH_RESET = 8'd100;

    // register index taken from the word address
    localparam logic REG_ALARM_THRESHOLD = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_STEP,
        ST_FINISH
    } smed_state_t;

    typedef struct packed {
        logic                done;
        logic [SAMPLE_W-1:0] median;
    } smed_result_t;

endpackage

`default_nettype wire

FILE: rtl/core/smed_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module smed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 60,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/smed_seq.sv
// ring bookkeeping and bitwise rank search over the stored samples
`default_nettype none

module smed_seq
    import smed_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF,
    parameter int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1,
    parameter int CNT_W  = $clog2(WINDOW + 1)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [SAMPLE_W-1:0] sample,
    input  wire logic                out_free,
    output logic                     idle,
    output smed_result_t             result
);

    smed_state_t state_reg, state_next;

    logic [SLOT_W-1:0]    wslot_reg, wslot_next;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic [SLOT_W-1:0]    idx_reg, idx_next;
    logic                 rvalid_reg, rvalid_next;
    logic [CNT_W-1:0]     cnt_lo_reg, cnt_lo_next;
    logic [CNT_W-1:0]     cnt_hi_reg, cnt_hi_next;
    logic [SAMPLE_W-1:0]  v_lo_reg, v_lo_next;
    logic [SAMPLE_W-1:0]  v_hi_reg, v_hi_next;
    logic [BIT_IDX_W-1:0] bit_reg, bit_next;

    logic [SAMPLE_W-1:0]  rd_data;
    logic [SLOT_W-1:0]    rd_addr;
    logic [SAMPLE_W-1:0]  bit_mask;
    logic [SAMPLE_W-1:0]  t_lo;
    logic [SAMPLE_W-1:0]  t_hi;
    logic [CNT_W-1:0]     rank_hi;
    logic [CNT_W-1:0]     rank_lo;
    logic                 last_idx;
    logic [SAMPLE_W:0]    mid_sum;

    smed_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW),
        .AW    (SLOT_W)
    ) u_ring (
        .clk   (clk),
        .we    (start),
        .waddr (wslot_reg),
        .wdata (sample),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign rd_addr  = idx_reg;
    assign bit_mask = SAMPLE_W'(1) << bit_reg;
    assign t_lo     = v_lo_reg | bit_mask;
    assign t_hi     = v_hi_reg | bit_mask;
    // upper middle rank, and lower middle rank (same for an odd count)
    assign rank_hi  = fill_reg >> 1;
    assign rank_lo  = fill_reg[0] ? rank_hi : rank_hi - CNT_W'(1);
    assign last_idx = (CNT_W'(idx_reg) == fill_reg - CNT_W'(1));
    assign mid_sum  = {1'b0, v_lo_reg} + {1'b0, v_hi_reg};

    assign idle          = (state_reg == ST_IDLE);
    assign result.done   = (state_reg == ST_FINISH) && out_free;
    assign result.median = mid_sum[SAMPLE_W:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            wslot_reg  <= '0;
            fill_reg   <= '0;
            idx_reg    <= '0;
            rvalid_reg <= 1'b0;
            cnt_lo_reg <= '0;
            cnt_hi_reg <= '0;
            v_lo_reg   <= '0;
            v_hi_reg   <= '0;
            bit_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            wslot_reg  <= wslot_next;
            fill_reg   <= fill_next;
            idx_reg    <= idx_next;
            rvalid_reg <= rvalid_next;
            cnt_lo_reg <= cnt_lo_next;
            cnt_hi_reg <= cnt_hi_next;
            v_lo_reg   <= v_lo_next;
            v_hi_reg   <= v_hi_next;
            bit_reg    <= bit_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        wslot_next  = wslot_reg;
        fill_next   = fill_reg;
        idx_next    = idx_reg;
        rvalid_next = 1'b0;
        cnt_lo_next = cnt_lo_reg;
        cnt_hi_next = cnt_hi_reg;
        v_lo_next   = v_lo_reg;
        v_hi_next   = v_hi_reg;
        bit_next    = bit_reg;

        // count stored samples below each candidate, one per cycle
        if (rvalid_reg)
        begin
            if (rd_data < t_lo)
            begin
                cnt_lo_next = cnt_lo_reg + CNT_W'(1);
            end
            if (rd_data < t_hi)
            begin
                cnt_hi_next = cnt_hi_reg + CNT_W'(1);
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (wslot_reg == SLOT_W'(WINDOW - 1))
                    begin
                        wslot_next = '0;
                    end
                    else
                    begin
                        wslot_next = wslot_reg + SLOT_W'(1);
                    end
                    if (fill_reg != CNT_W'(WINDOW))
                    begin
                        fill_next = fill_reg + CNT_W'(1);
                    end
                    idx_next    = '0;
                    cnt_lo_next = '0;
                    cnt_hi_next = '0;
                    v_lo_next   = '0;
                    v_hi_next   = '0;
                    bit_next    = BIT_IDX_W'(SAMPLE_W - 1);
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                rvalid_next = 1'b1;
                if (last_idx)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                // keep the bit while at most rank samples lie below the candidate
                if (cnt_lo_reg <= rank_lo)
                begin
                    v_lo_next = t_lo;
                end
                if (cnt_hi_reg <= rank_hi)
                begin
                    v_hi_next = t_hi;
                end
                cnt_lo_next = '0;
                cnt_hi_next = '0;
                idx_next    = '0;
                if (bit_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    bit_next   = bit_reg - BIT_IDX_W'(1);
                    state_next = ST_SCAN;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/sliding_median_alarm.sv
// top level: running median of recent sensor samples with threshold alarm
//
// s_* channel takes one sample per item; m_* channel gives one result item
// per sample: the median of the filled window (this sample included) and
// the sample echoed back, with the alarm flag on tuser.
// the alarm threshold is written over the apb port (register 0, reset 100);
// write it only while no item is in flight.
// each item is counted against the stored samples once per result bit,
// the single ring read port feeding the compare unit one sample per cycle.
// s_tready is high only while the sequencer is idle, so one item is in the
// work at a time; the next item is taken only once the previous result
// has moved into the output register.
// a result waiting in the output register does not block the next accept,
// but the next result waits until m_tready takes it.
// reset clears the fill count and write slot (ring contents are never
// read before written), drops m_tvalid and restores the threshold.
`default_nettype none

module sliding_median_alarm
    import smed_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // apb configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [SAMPLE_W-1:0]   s_tdata,   // [7:0] sample
    // output stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [OUT_DATA_W-1:0] m_tdata,   // [7:0] median_value, [15:8] echo_sample
    output logic                       m_tuser    // [0] alarm
);

    logic [SAMPLE_W-1:0]   thresh_reg, thresh_next;
    logic [SAMPLE_W-1:0]   sample_reg, sample_next;
    logic                  alarm_reg, alarm_next;
    logic                  mvalid_reg, mvalid_next;
    logic [OUT_DATA_W-1:0] mdata_reg, mdata_next;
    logic                  muser_reg, muser_next;

    logic         cfg_wr;
    logic         in_accept;
    logic         seq_idle;
    logic         out_free;
    smed_result_t seq_res;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready && (paddr[2] == REG_ALARM_THRESHOLD);
    assign prdata    = (paddr[2] == REG_ALARM_THRESHOLD)
                       ? {{(APB_DATA_W - SAMPLE_W){1'b0}}, thresh_reg} : '0;

    assign s_tready  = seq_idle;
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !mvalid_reg || m_tready;

    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = mdata_reg;
    assign m_tuser   = muser_reg;

    smed_seq #(
        .WINDOW (WINDOW)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_accept),
        .sample   (s_tdata),
        .out_free (out_free),
        .idle     (seq_idle),
        .result   (seq_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            thresh_reg <= thresh_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        alarm_reg  <= alarm_next;
        mdata_reg  <= mdata_next;
        muser_reg  <= muser_next;
    end

    always_comb
    begin
        thresh_next = thresh_reg;
        sample_next = sample_reg;
        alarm_next  = alarm_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        muser_next  = muser_reg;

        if (cfg_wr)
        begin
            thresh_next = pwdata[SAMPLE_W-1:0];
        end

        if (in_accept)
        begin
            sample_next = s_tdata;
            alarm_next  = (s_tdata > thresh_reg);
        end

        if (m_tready)
        begin
            mvalid_next = 1'b0;
        end
        if (seq_res.done)
        begin
            mvalid_next = 1'b1;
            mdata_next  = {sample_reg, seq_res.median};
            muser_next  = alarm_reg;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/smed_checker.sv
// port-level checks for the sliding median block, bound to the top level
`default_nettype none

module smed_checker
    import smed_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  psel,
    input wire logic                  penable,
    input wire logic                  pwrite,
    input wire logic [APB_ADDR_W-1:0] paddr,
    input wire logic [APB_DATA_W-1:0] pwdata,
    input wire logic [APB_DATA_W-1:0] prdata,
    input wire logic                  pready,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata,
    input wire logic                  m_tuser
);

    logic s_acc;
    logic thr_wr;

    assign s_acc  = s_tvalid && s_tready;
    assign thr_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ALARM_THRESHOLD);

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc |=> !s_tready)
        else $error("input ready right after an accept");

    // the search is not combinational, no result appears straight after an accept
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc |=> !$rose(m_tvalid))
        else $error("result appeared one cycle after accept");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // threshold reads back what was written
    a_thresh_readback: assert property (@(posedge clk) disable iff (!rst_n)
        thr_wr |=> ((paddr[2] != REG_ALARM_THRESHOLD)
                    || (prdata == {{(APB_DATA_W - SAMPLE_W){1'b0}},
                                   $past(pwdata[SAMPLE_W-1:0])})))
        else $error("threshold readback mismatch");

endmodule

bind sliding_median_alarm smed_checker u_smed_checker (.*);

`default_nettype wire
